// ----- sv/rcr_pkg.sv -----
// ============================================================================
// rcr_pkg
// Shared types and constants for the rolling capture ring.
// ============================================================================
package rcr_pkg;

    localparam int StepW    = 32;
    localparam int CountW   = 32;
    localparam int SlotW    = 5;
    localparam int FcW      = 6;
    localparam int InDataW  = 64;
    localparam int OutDataW = 72;
    localparam int OutPadW  = OutDataW - StepW - CountW - SlotW;

    localparam logic [FcW-1:0] FcReset = 6'd32;

    localparam logic ReqRecord  = 1'b0;
    localparam logic ReqReadout = 1'b1;

    localparam logic ErrNone       = 1'b0;
    localparam logic ErrIncomplete = 1'b1;

    typedef struct packed {
        logic rec;
        logic start;
        logic issue;
        logic err;
    } ctl_cmd_t;

    typedef struct packed {
        logic full;
        logic rd_last;
        logic out_valid;
    } ctl_stat_t;

endpackage

// ----- sv/rcr_ctrl.sv -----
// ============================================================================
// rcr_ctrl
// Request sequencer: accepts requests and steps through a read-out.
// ============================================================================
module rcr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_req,
    output logic               in_ready,
    input  logic               out_ready,
    input  rcr_pkg::ctl_stat_t stat,
    output rcr_pkg::ctl_cmd_t  cmd
);
    import rcr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_ERR
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_free;
    logic   in_fire;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid & in_ready;
    assign out_free = ~stat.out_valid | out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_req == ReqRecord)
                    begin
                        cmd.rec = 1'b1;
                    end
                    else if (stat.full)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_ERR;
                    end
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    cmd.issue = 1'b1;
                    if (stat.rd_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    cmd.err    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/rcr_datapath.sv -----
// ============================================================================
// rcr_datapath
// Capture store, ring pointers, frame count register and output register.
// ============================================================================
module rcr_datapath #(
    parameter int MAX_FRAMES = 32
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_we,
    input  logic [rcr_pkg::FcW-1:0]                    cfg_data,
    input  logic [rcr_pkg::StepW-1:0]                  in_step,
    input  logic [rcr_pkg::CountW-1:0]                 in_count,
    input  rcr_pkg::ctl_cmd_t                          cmd,
    output rcr_pkg::ctl_stat_t                         stat,
    input  logic                                       out_ready,
    output logic                                       out_valid,
    output logic [rcr_pkg::StepW-1:0]                  out_step,
    output logic [rcr_pkg::CountW-1:0]                 out_count,
    output logic [rcr_pkg::SlotW-1:0]                  out_slot,
    output logic                                       out_err,
    output logic                                       out_last
);
    import rcr_pkg::*;

    localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam logic [FcW:0] MaxWide = (FcW + 1)'(MAX_FRAMES);

    logic [StepW+CountW-1:0] mem [MAX_FRAMES];

    logic [FcW-1:0] fc_reg;
    logic [AW-1:0]  wp_reg;
    logic [AW-1:0]  wp_next;
    logic [CW-1:0]  ret_reg;
    logic [CW-1:0]  ret_next;
    logic [AW-1:0]  rd_idx_reg;
    logic [AW-1:0]  rd_idx_next;
    logic [CW-1:0]  rd_off_reg;
    logic [CW-1:0]  rd_off_next;
    logic           valid_reg;
    logic           valid_next;

    logic [StepW-1:0]  step_reg;
    logic [CountW-1:0] count_reg;
    logic [SlotW-1:0]  slot_reg;
    logic              err_reg;
    logic              last_reg;

    logic [FcW:0]   fc_wide;
    logic [CW-1:0]  n_eff;
    logic [CW-1:0]  wp_inc;
    logic [CW-1:0]  rd_inc;
    logic [CW-1:0]  off_inc;
    logic           do_write;

    assign fc_wide  = {1'b0, fc_reg};
    assign n_eff    = CW'((fc_wide > MaxWide) ? MaxWide : fc_wide);
    assign do_write = cmd.rec & (n_eff != '0);
    assign wp_inc   = CW'(wp_reg) + CW'(1);
    assign rd_inc   = CW'(rd_idx_reg) + CW'(1);
    assign off_inc  = rd_off_reg + CW'(1);

    assign stat.full      = (n_eff != '0) & (ret_reg == n_eff);
    assign stat.rd_last   = (off_inc == n_eff);
    assign stat.out_valid = valid_reg;

    always_comb
    begin
        wp_next     = wp_reg;
        ret_next    = ret_reg;
        rd_idx_next = rd_idx_reg;
        rd_off_next = rd_off_reg;
        valid_next  = valid_reg & ~out_ready;
        if (cfg_we)
        begin
            wp_next  = '0;
            ret_next = '0;
        end
        else if (do_write)
        begin
            wp_next = (wp_inc >= n_eff) ? '0 : AW'(wp_inc);
            if (ret_reg < n_eff)
            begin
                ret_next = ret_reg + CW'(1);
            end
        end
        if (cmd.start)
        begin
            rd_idx_next = wp_reg;
            rd_off_next = '0;
        end
        else if (cmd.issue)
        begin
            rd_idx_next = (rd_inc >= n_eff) ? '0 : AW'(rd_inc);
            rd_off_next = off_inc;
        end
        if (cmd.issue | cmd.err)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg     <= FcReset;
            wp_reg     <= '0;
            ret_reg    <= '0;
            rd_idx_reg <= '0;
            rd_off_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fc_reg <= cfg_data;
            end
            wp_reg     <= wp_next;
            ret_reg    <= ret_next;
            rd_idx_reg <= rd_idx_next;
            rd_off_reg <= rd_off_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[wp_reg] <= {in_count, in_step};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            {count_reg, step_reg} <= mem[rd_idx_reg];
            slot_reg              <= SlotW'(rd_idx_reg);
            err_reg               <= ErrNone;
            last_reg              <= stat.rd_last;
        end
        else if (cmd.err)
        begin
            count_reg <= '0;
            step_reg  <= '0;
            slot_reg  <= '0;
            err_reg   <= ErrIncomplete;
            last_reg  <= 1'b1;
        end
    end

    assign out_valid = valid_reg;
    assign out_step  = step_reg;
    assign out_count = count_reg;
    assign out_slot  = slot_reg;
    assign out_err   = err_reg;
    assign out_last  = last_reg;

endmodule

// ----- sv/rolling_capture_ring.sv -----
// ============================================================================
// rolling_capture_ring
// Rolling ring of capture records with oldest-first read-out.
// ============================================================================
// A record is written on acceptance and the next request is taken in the following cycle.
// A read-out emits one slot per cycle, while the output is empty or being taken, from the store's
// registered read port into the output register; no new request is taken until the last slot.
// An incomplete-history read-out gives one error result once the output is free, then idles.
// Reset clears the pointers and sets the slot count to 32; the store itself is not cleared.
module rolling_capture_ring #(
    parameter int MAX_FRAMES = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // step_number [31:0], particle_total [63:32]
    input  logic [rcr_pkg::InDataW-1:0]     s_axis_tdata,
    // req_type [0]
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // captured_step [31:0], captured_particles [63:32], slot_index [68:64], zero [71:69]
    output logic [rcr_pkg::OutDataW-1:0]    m_axis_tdata,
    // error_code [0]
    output logic [0:0]                      m_axis_tuser,
    output logic                            m_axis_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rcr_pkg::FcW-1:0]         cfg_data
);
    import rcr_pkg::*;

    ctl_cmd_t           cmd;
    ctl_stat_t          stat;
    logic [StepW-1:0]   out_step;
    logic [CountW-1:0]  out_count;
    logic [SlotW-1:0]   out_slot;
    logic               out_err;

    assign cfg_ready = 1'b1;

    rcr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_req    (s_axis_tuser[0]),
        .in_ready  (s_axis_tready),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rcr_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_data  (cfg_data),
        .in_step   (s_axis_tdata[StepW-1:0]),
        .in_count  (s_axis_tdata[StepW+CountW-1:StepW]),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_step  (out_step),
        .out_count (out_count),
        .out_slot  (out_slot),
        .out_err   (out_err),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata    = {{OutPadW{1'b0}}, out_slot, out_count, out_step};
    assign m_axis_tuser[0] = out_err;

endmodule
